### src/ppmrc_pkg.sv
// Shared types, constants and helper functions for the PPM RC channel decoder.
// No dependencies; compiled first.
package ppmrc_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int IDX_W        = $clog2(NUM_CHANNELS + 1);
  localparam int TIME_W       = 32;
  localparam int CH_W         = 11;
  localparam int STICK_W      = 10;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;

  // op codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SYNC_GAP   = 3'd0;
  localparam logic [2:0] REG_WIN_LOW    = 3'd1;
  localparam logic [2:0] REG_WIN_HIGH   = 3'd2;
  localparam logic [2:0] REG_CENTER     = 3'd3;
  localparam logic [2:0] REG_DEADZONE   = 3'd4;
  localparam logic [2:0] REG_TIMEOUT    = 3'd5;

  localparam logic [15:0]       SYNC_GAP_RST = 16'd2100;
  localparam logic [15:0]       WIN_LOW_RST  = 16'd950;
  localparam logic [15:0]       WIN_HIGH_RST = 16'd2050;
  localparam logic [CH_W-1:0]   CENTER_RST   = 11'd1500;
  localparam logic [8:0]        DEADZONE_RST = 9'd50;
  localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd80000;

  localparam logic [CH_W-1:0] CH_MIN      = 11'd1000;
  localparam logic [CH_W-1:0] CH_MAX      = 11'd2000;
  localparam logic [CH_W-1:0] CH_MID      = 11'd1500;
  localparam logic [CH_W-1:0] SW3_LOW     = 11'd1250;
  localparam logic [CH_W-1:0] SW3_HIGH    = 11'd1750;
  localparam int              STICK_LIMIT = 500;
  localparam int              NUM_STICKS  = 4;

  typedef logic [NUM_CHANNELS-1:0][CH_W-1:0] ppmrc_chans_t;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_us;
  } ppmrc_item_t;

  typedef struct packed {
    logic [15:0]       sync_gap_us;
    logic [15:0]       pulse_window_low;
    logic [15:0]       pulse_window_high;
    logic [CH_W-1:0]   stick_center;
    logic [8:0]        stick_deadzone;
    logic [TIME_W-1:0] link_timeout_us;
  } ppmrc_cfg_t;

  // reset content of a channel slot: sticks centered, switches low
  function automatic logic [CH_W-1:0] chan_reset(int i);
    return (i < NUM_STICKS) ? CH_MID : '0;
  endfunction

  // centered stick with deadzone removed, saturated to +/-500
  function automatic logic signed [STICK_W-1:0] stick_map(logic [CH_W-1:0] ch,
                                                         logic [CH_W-1:0] center,
                                                         logic [8:0] dz);
    logic signed [12:0] t;
    logic signed [12:0] d;
    logic signed [12:0] r;
    t = $signed({2'b00, ch}) - $signed({2'b00, center});
    d = $signed({4'b0000, dz});
    if (t > -d && t < d) begin
      r = '0;
    end else if (t >= d) begin
      r = t - d;
    end else begin
      r = t + d;
    end
    if (r > 13'(STICK_LIMIT)) begin
      r = 13'(STICK_LIMIT);
    end else if (r < -13'(STICK_LIMIT)) begin
      r = -13'(STICK_LIMIT);
    end
    return r[STICK_W-1:0];
  endfunction

  function automatic logic [1:0] three_pos(logic [CH_W-1:0] ch);
    if (ch <= SW3_LOW) begin
      return 2'd0;
    end else if (ch <= SW3_HIGH) begin
      return 2'd1;
    end
    return 2'd2;
  endfunction

endpackage

### src/ppmrc_if.sv
// Valid/ready channel interfaces for decoder requests and results.
// Depends on ppmrc_pkg for field widths.
interface ppmrc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [ppmrc_pkg::TIME_W-1:0]  now_us;
  modport source (output valid, op, now_us, input ready);
  modport sink   (input valid, op, now_us, output ready);
endinterface

interface ppmrc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppmrc_pkg::STICK_W-1:0] left_x;
  logic signed [ppmrc_pkg::STICK_W-1:0] left_y;
  logic signed [ppmrc_pkg::STICK_W-1:0] right_x;
  logic signed [ppmrc_pkg::STICK_W-1:0] right_y;
  logic                                switch_a;
  logic [1:0]                          switch_b;
  logic [1:0]                          switch_c;
  logic                                switch_d;
  logic                                switch_a_changed;
  logic                                switch_d_changed;
  logic                                link_ok;
  modport source (output valid, left_x, left_y, right_x, right_y, switch_a, switch_b,
                  switch_c, switch_d, switch_a_changed, switch_d_changed, link_ok,
                  input ready);
  modport sink   (input valid, left_x, left_y, right_x, right_y, switch_a, switch_b,
                  switch_c, switch_d, switch_a_changed, switch_d_changed, link_ok,
                  output ready);
endinterface

### src/ppmrc_frame.sv
// Edge interval classifier and channel frame store (pending and latched sets).
// Depends on ppmrc_pkg.
module ppmrc_frame import ppmrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [TIME_W-1:0] now_us,
  input  ppmrc_cfg_t        cfg,
  output logic [TIME_W-1:0] last_edge_time,
  output ppmrc_chans_t      latched
);

  logic [IDX_W-1:0]  channel_index;
  logic [IDX_W-1:0]  channel_index_next;
  ppmrc_chans_t      pending;
  ppmrc_chans_t      pending_next;
  logic [TIME_W-1:0] delta;
  logic              in_window;
  logic              do_store;
  logic [CH_W-1:0]   clamped;

  assign delta     = now_us - last_edge_time;
  assign in_window = (delta > {16'd0, cfg.pulse_window_low}) &&
                     (delta < {16'd0, cfg.pulse_window_high});

  always_comb begin
    if (delta < TIME_W'(CH_MIN)) begin
      clamped = CH_MIN;
    end else if (delta > TIME_W'(CH_MAX)) begin
      clamped = CH_MAX;
    end else begin
      clamped = delta[CH_W-1:0];
    end
  end

  always_comb begin
    do_store           = 1'b0;
    channel_index_next = channel_index;
    if (delta > {16'd0, cfg.sync_gap_us}) begin
      channel_index_next = '0;
    end else if (in_window) begin
      if (channel_index < IDX_W'(NUM_CHANNELS)) begin
        do_store           = 1'b1;
        channel_index_next = channel_index + IDX_W'(1);
      end
    end else begin
      channel_index_next = '0;
    end
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pending_next[i] = (do_store && channel_index == IDX_W'(i)) ? clamped : pending[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      channel_index  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pending[i] <= chan_reset(i);
        latched[i] <= chan_reset(i);
      end
    end else if (fire) begin
      last_edge_time <= now_us;
      channel_index  <= channel_index_next;
      pending        <= pending_next;
      if (channel_index_next == IDX_W'(NUM_CHANNELS)) begin
        latched <= pending_next;
      end
    end
  end

endmodule

### src/ppm_rc_channel_decoder_core.sv
// PPM RC channel decoder top level: APB register file, input stage, output stage.
// Depends on ppmrc_pkg, ppmrc_if and ppmrc_frame.
//
// Path: a poll transfer passes the input register, then the result register,
//   before its result appears; edge transfers yield nothing.
// Throughput: one transfer per cycle; the output register stalls only polls,
//   edges drain from the input register regardless of the result side.
// Reset (rst, synchronous, active high): registers take their defaults, the
//   channel frame returns to centered sticks, both stages empty.
module ppm_rc_channel_decoder_core import ppmrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  ppmrc_req_if.sink             req,
  ppmrc_rsp_if.source           rsp
);

  // ---------------- configuration registers ----------------
  ppmrc_cfg_t       cfg;
  logic [2:0]       reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_gap_us       <= SYNC_GAP_RST;
      cfg.pulse_window_low  <= WIN_LOW_RST;
      cfg.pulse_window_high <= WIN_HIGH_RST;
      cfg.stick_center      <= CENTER_RST;
      cfg.stick_deadzone    <= DEADZONE_RST;
      cfg.link_timeout_us   <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SYNC_GAP: cfg.sync_gap_us       <= pwdata[15:0];
        REG_WIN_LOW:  cfg.pulse_window_low  <= pwdata[15:0];
        REG_WIN_HIGH: cfg.pulse_window_high <= pwdata[15:0];
        REG_CENTER:   cfg.stick_center      <= pwdata[CH_W-1:0];
        REG_DEADZONE: cfg.stick_deadzone    <= pwdata[8:0];
        REG_TIMEOUT:  cfg.link_timeout_us   <= pwdata;
        default: ;    // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_GAP: prdata = {16'd0, cfg.sync_gap_us};
      REG_WIN_LOW:  prdata = {16'd0, cfg.pulse_window_low};
      REG_WIN_HIGH: prdata = {16'd0, cfg.pulse_window_high};
      REG_CENTER:   prdata = {21'd0, cfg.stick_center};
      REG_DEADZONE: prdata = {23'd0, cfg.stick_deadzone};
      REG_TIMEOUT:  prdata = cfg.link_timeout_us;
      default:      prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  // s1 holds one accepted transfer. An edge always retires; a poll retires
  // when the result register is free or is being drained this cycle.
  logic        s1_valid;
  ppmrc_item_t s1_item;
  logic        s1_go;
  logic        edge_fire;
  logic        poll_load;
  logic        rsp_valid;

  assign s1_go     = s1_valid && (s1_item.op == OP_EDGE || !rsp_valid || rsp.ready);
  assign edge_fire = s1_go && s1_item.op == OP_EDGE;
  assign poll_load = s1_go && s1_item.op == OP_POLL;
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= '{op: req.op, now_us: req.now_us};
    end
  end

  // ---------------- frame store ----------------
  logic [TIME_W-1:0] last_edge_time;
  ppmrc_chans_t      latched;

  ppmrc_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .fire           (edge_fire),
    .now_us         (s1_item.now_us),
    .cfg            (cfg),
    .last_edge_time (last_edge_time),
    .latched        (latched)
  );

  // ---------------- poll mapping ----------------
  logic [TIME_W-1:0]         poll_delta;
  logic                      ok;
  logic signed [STICK_W-1:0] lx, ly, rx, ry;
  logic                      sa, sd;
  logic [1:0]                sb, sc;
  logic                      prev_switch_a, prev_switch_d, prev_seeded;
  logic                      prev_a_eff, prev_d_eff;

  assign poll_delta = s1_item.now_us - last_edge_time;
  assign ok         = poll_delta < cfg.link_timeout_us;

  always_comb begin
    lx = '0;
    ly = '0;
    rx = '0;
    ry = '0;
    sa = 1'b0;
    sb = 2'd0;
    sc = 2'd0;
    sd = 1'b0;
    if (ok) begin
      // stick order on the wire: ch0 left x, ch1 right y, ch2 left y, ch3 right x
      lx = stick_map(latched[0], cfg.stick_center, cfg.stick_deadzone);
      ly = stick_map(latched[2], cfg.stick_center, cfg.stick_deadzone);
      rx = stick_map(latched[3], cfg.stick_center, cfg.stick_deadzone);
      ry = stick_map(latched[1], cfg.stick_center, cfg.stick_deadzone);
      sa = latched[4] > CH_MID;
      sb = three_pos(latched[5]);
      sc = three_pos(latched[6]);
      sd = latched[7] > CH_MID;
    end
  end

  // first poll with a live link seeds the history, so it reports no change
  assign prev_a_eff = (ok && !prev_seeded) ? sa : prev_switch_a;
  assign prev_d_eff = (ok && !prev_seeded) ? sd : prev_switch_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_switch_a <= 1'b0;
      prev_switch_d <= 1'b0;
      prev_seeded   <= 1'b0;
    end else if (poll_load) begin
      prev_switch_a <= sa;
      prev_switch_d <= sd;
      prev_seeded   <= prev_seeded | ok;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (poll_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_load) begin
      rsp.left_x           <= lx;
      rsp.left_y           <= ly;
      rsp.right_x          <= rx;
      rsp.right_y          <= ry;
      rsp.switch_a         <= sa;
      rsp.switch_b         <= sb;
      rsp.switch_c         <= sc;
      rsp.switch_d         <= sd;
      rsp.switch_a_changed <= sa ^ prev_a_eff;
      rsp.switch_d_changed <= sd ^ prev_d_eff;
      rsp.link_ok          <= ok;
    end
  end

  assign rsp.valid = rsp_valid;

`ifndef SYNTHESIS
  // a retiring poll always lands in the result register
  assert property (@(posedge clk) disable iff (rst) poll_load |=> rsp_valid)
    else $error("poll retired without a result");

  // a dead link reports everything at zero
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.link_ok) |-> (rsp.left_x == '0 && rsp.left_y == '0 &&
      rsp.right_x == '0 && rsp.right_y == '0 && !rsp.switch_a && !rsp.switch_d &&
      rsp.switch_b == 2'd0 && rsp.switch_c == 2'd0))
    else $error("nonzero controls with link down");

  // left_x and right_y stay inside the saturation band
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.left_x >= -10'sd500 && rsp.left_x <= 10'sd500 &&
                   rsp.right_y >= -10'sd500 && rsp.right_y <= 10'sd500))
    else $error("stick out of range");

  // first live poll after reset never flags a switch change
  assert property (@(posedge clk) disable iff (rst)
    (poll_load && ok && !prev_seeded) |=> (!rsp.switch_a_changed && !rsp.switch_d_changed))
    else $error("change flagged on seeding poll");
`endif

endmodule
